>>> hdl/pisd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette image stream decoder package
// Shared sizes, status codes, color constants and the parser-to-output
// request descriptor.
// ----------------------------------------------------------------------------
package pisd_pkg;

   // sizing
   localparam int PALETTE_DEPTH = 256;
   localparam int MAX_DIM       = 4096;

   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 16;
   localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int PIX_W   = $clog2(longint'(MAX_DIM) * longint'(MAX_DIM) + 64'd1);

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_DIM   = 2'd2;

   // alpha nibble handling
   localparam logic [COLOR_W-1:0] ALPHA_CLEAR_MASK = 16'h0FFF;
   localparam logic [COLOR_W-1:0] ALPHA_SET_BITS   = 16'hF000;

   // descriptor of a result produced by one accepted request
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       last;
      logic       clear_alpha;
   } issue_type;

endpackage
`default_nettype wire

>>> hdl/pisd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module pisd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/pisd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette image stream parser
// Header and palette parse state; one byte per accepted request. Writes the
// palette RAM, issues the pixel read and describes the result, if any.
// ----------------------------------------------------------------------------
module pisd_parser (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               take,
   input  wire logic [pisd_pkg::BYTE_W-1:0]        data_byte,
   input  wire logic                               start_of_file,
   output logic                                    pal_wr_en,
   output logic      [pisd_pkg::PAL_AW-1:0]        pal_wr_addr,
   output logic      [pisd_pkg::COLOR_W-1:0]       pal_wr_data,
   output logic      [pisd_pkg::PAL_AW-1:0]        pal_rd_addr,
   output pisd_pkg::issue_type                     issue
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_WIDTH   = 3'd1;
   localparam logic [2:0] PH_HEIGHT  = 3'd2;
   localparam logic [2:0] PH_FLAG    = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_COUNT   = 3'd5;
   localparam logic [2:0] PH_PALETTE = 3'd6;
   localparam logic [2:0] PH_PIXELS  = 3'd7;

   localparam int DW = pisd_pkg::DIM_W;
   localparam int PW = pisd_pkg::PIX_W;

   logic [2:0]                    phase_ff, phase_in;
   logic [1:0]                    cnt_ff, cnt_in;
   logic [23:0]                   shift_ff, shift_in;
   logic [DW-1:0]                 width_ff, width_in;
   logic [DW-1:0]                 height_ff, height_in;
   logic                          key_en_ff, key_en_in;
   logic [15:0]                   key_ff, key_in;
   logic [7:0]                    count_ff, count_in;
   logic [7:0]                    fill_ff, fill_in;
   logic                          found_ff, found_in;
   logic [7:0]                    trans_ff, trans_in;
   logic [PW-1:0]                 remain_ff, remain_in;

   logic [2:0]                    ph;
   logic [1:0]                    cnt;
   logic [31:0]                   raw;
   logic [15:0]                   word16;
   logic                          too_large;
   logic [DW-1:0]                 dim;
   logic [8:0]                    usable;
   logic [7:0]                    fill_next;
   logic [2:0]                    after_pal;
   logic                          pal_slot_ok;

   // a start flag restarts the parse from any phase
   assign ph  = start_of_file ? PH_WIDTH : phase_ff;
   assign cnt = start_of_file ? 2'd0 : cnt_ff;

   assign raw       = {shift_ff, data_byte};
   assign word16    = {shift_ff[7:0], data_byte};
   assign too_large = !raw[31] && (raw > 32'(pisd_pkg::MAX_DIM));
   assign dim       = (raw[31] || too_large) ? '0 : raw[DW-1:0];
   assign usable    = ({1'b0, count_ff} < 9'(pisd_pkg::PALETTE_DEPTH)) ?
                      {1'b0, count_ff} : 9'(pisd_pkg::PALETTE_DEPTH);
   assign fill_next = fill_ff + 8'd1;
   assign after_pal = (remain_ff != '0) ? PH_PIXELS : PH_IDLE;
   assign pal_slot_ok = {1'b0, fill_ff} < 9'(pisd_pkg::PALETTE_DEPTH);

   assign pal_wr_addr = fill_ff[pisd_pkg::PAL_AW-1:0];
   assign pal_wr_data = word16;
   assign pal_rd_addr = data_byte[pisd_pkg::PAL_AW-1:0];

   always_comb begin
      phase_in  = ph;
      cnt_in    = cnt;
      shift_in  = shift_ff;
      width_in  = width_ff;
      height_in = height_ff;
      key_en_in = key_en_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      fill_in   = fill_ff;
      found_in  = found_ff;
      trans_in  = trans_ff;
      remain_in = remain_ff;
      pal_wr_en = 1'b0;
      issue     = '0;

      unique case (ph) inside
         PH_WIDTH, PH_HEIGHT: begin
            shift_in = raw[23:0];
            cnt_in   = cnt + 2'd1;
            if (cnt == 2'd3) begin
               if (too_large) begin
                  phase_in     = PH_IDLE;
                  issue.valid  = 1'b1;
                  issue.status = pisd_pkg::STATUS_DIM;
               end else if (ph == PH_WIDTH) begin
                  width_in = dim;
                  phase_in = PH_HEIGHT;
               end else begin
                  height_in = dim;
                  phase_in  = PH_FLAG;
               end
            end
         end
         PH_FLAG: begin
            // height is final here; the pixel total is formed one byte late
            key_en_in = data_byte != '0;
            cnt_in    = 2'd0;
            remain_in = PW'(width_ff) * PW'(height_ff);
            phase_in  = PH_KEY;
         end
         PH_KEY: begin
            shift_in = raw[23:0];
            cnt_in   = cnt + 2'd1;
            if (cnt == 2'd1) begin
               key_in   = word16;
               cnt_in   = 2'd0;
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            count_in = data_byte;
            fill_in  = '0;
            found_in = 1'b0;
            cnt_in   = 2'd0;
            phase_in = (data_byte != '0) ? PH_PALETTE : after_pal;
         end
         PH_PALETTE: begin
            shift_in = raw[23:0];
            cnt_in   = cnt + 2'd1;
            if (cnt == 2'd1) begin
               cnt_in = 2'd0;
               if (pal_slot_ok) begin
                  pal_wr_en = 1'b1;
                  if (key_en_ff && !found_ff && word16 == key_ff) begin
                     found_in = 1'b1;
                     trans_in = fill_ff;
                  end
               end
               fill_in = fill_next;
               if (fill_next == count_ff) begin
                  phase_in = after_pal;
               end
            end
         end
         PH_PIXELS: begin
            issue.valid = 1'b1;
            if ({1'b0, data_byte} >= usable) begin
               phase_in     = PH_IDLE;
               issue.status = pisd_pkg::STATUS_RANGE;
            end else begin
               issue.status      = pisd_pkg::STATUS_OK;
               issue.last        = remain_ff == PW'(1);
               issue.clear_alpha = key_en_ff && found_ff && (data_byte == trans_ff);
               remain_in         = remain_ff - PW'(1);
               if (remain_ff == PW'(1)) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (!take) begin
         pal_wr_en = 1'b0;
         issue     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         shift_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         key_en_ff <= 1'b0;
         key_ff    <= '0;
         count_ff  <= '0;
         fill_ff   <= '0;
         found_ff  <= 1'b0;
         trans_ff  <= '0;
         remain_ff <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         shift_ff  <= shift_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         key_en_ff <= key_en_in;
         key_ff    <= key_in;
         count_ff  <= count_in;
         fill_ff   <= fill_in;
         found_ff  <= found_in;
         trans_ff  <= trans_in;
         remain_ff <= remain_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/pisd_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette image stream output stage
// Holds the descriptor beside the palette read data, applies the alpha
// nibble and drives the result register. Generates input back-pressure.
// ----------------------------------------------------------------------------
module pisd_out (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               take,
   input  wire pisd_pkg::issue_type                issue,
   input  wire logic [pisd_pkg::COLOR_W-1:0]       rd_data,
   input  wire logic                               rsp_stall,
   output logic                                    req_stall,
   output logic                                    rsp_valid,
   output logic      [pisd_pkg::COLOR_W-1:0]       rsp_pixel,
   output logic                                    rsp_last_pixel,
   output logic      [1:0]                         rsp_status
);

   pisd_pkg::issue_type              mid_ff;
   logic                             rsp_valid_ff;
   logic [pisd_pkg::COLOR_W-1:0]     pixel_ff, pixel_in;
   logic                             last_ff;
   logic [1:0]                       status_ff;
   logic                             advance;

   // result register frees when empty or taken this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = mid_ff.valid && !advance;

   always_comb begin
      if (mid_ff.status != pisd_pkg::STATUS_OK) begin
         pixel_in = '0;
      end else if (mid_ff.clear_alpha) begin
         pixel_in = rd_data & pisd_pkg::ALPHA_CLEAR_MASK;
      end else begin
         pixel_in = rd_data | pisd_pkg::ALPHA_SET_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            mid_ff <= issue;
         end else if (advance) begin
            mid_ff.valid <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= mid_ff.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff  <= pixel_in;
         last_ff   <= mid_ff.last;
         status_ff <= mid_ff.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel      = pixel_ff;
   assign rsp_last_pixel = last_ff;
   assign rsp_status     = status_ff;

endmodule
`default_nettype wire

>>> hdl/palette_image_stream_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette image stream decoder
// Parses an indexed-color image byte stream and expands each pixel index
// through a 16-bit palette with color-key transparency.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one stream byte per request (req_data_byte); set
//    req_start_of_file on the first width byte to (re)start a parse.
//  - rsp_ channel: one result per pixel byte, or one error result (index
//    out of range, dimension too large) after which the parser goes idle.
//    Other header bytes and palette bytes produce no result.
//  - Path: an accepted pixel request reads the palette RAM and registers
//    its descriptor; both then feed the result register behind rsp_valid.
//  - Throughput: one request per cycle while req_stall is low; limited by
//    the single palette read port, which serves one pixel per cycle.
//  - Stall: up to two results are buffered (the RAM read stage and the
//    result register); req_stall rises only when both hold data and the
//    receiver stalls.
//  - Reset: parser idle, no buffered results. Palette contents are not
//    cleared; a pixel only reads entries written for its own image.
// ----------------------------------------------------------------------------
module palette_image_stream_decoder_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pisd_pkg::BYTE_W-1:0]        req_data_byte,
   input  wire logic                               req_start_of_file,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [pisd_pkg::COLOR_W-1:0]       rsp_pixel,
   output logic                                    rsp_last_pixel,
   output logic      [1:0]                         rsp_status
);

   logic                               take;
   logic                               pal_wr_en;
   logic [pisd_pkg::PAL_AW-1:0]        pal_wr_addr;
   logic [pisd_pkg::COLOR_W-1:0]       pal_wr_data;
   logic [pisd_pkg::PAL_AW-1:0]        pal_rd_addr;
   logic [pisd_pkg::COLOR_W-1:0]       pal_rd_data;
   pisd_pkg::issue_type                issue;

   // request accepted this edge
   assign take = req_valid && !req_stall;

   // header / palette parse; writes palette, describes results
   pisd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req_data_byte),
      .start_of_file (req_start_of_file),
      .pal_wr_en     (pal_wr_en),
      .pal_wr_addr   (pal_wr_addr),
      .pal_wr_data   (pal_wr_data),
      .pal_rd_addr   (pal_rd_addr),
      .issue         (issue)
   );

   // palette store; read on every accepted request so the data lines up
   // with the descriptor held in the output stage
   pisd_ram #(
      .WIDTH (pisd_pkg::COLOR_W),
      .DEPTH (pisd_pkg::PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (take),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // alpha handling, result register, back-pressure
   pisd_out u_out (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .issue          (issue),
      .rd_data        (pal_rd_data),
      .rsp_stall      (rsp_stall),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_pixel      (rsp_pixel),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette image stream decoder testbench
// Streams directed and random image files into the decoder, one byte per
// request. It predicts every pixel and error result from its own copy of
// the header parser and palette, and checks each result field against the
// oldest prediction. Both sides idle at random, and the receiver holds off
// for long stretches so that the decoder fills and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

   // parser phases of the prediction
   typedef enum logic [2:0] {
      PH_IDLE, PH_WIDTH, PH_HEIGHT, PH_FLAG, PH_KEY, PH_COUNT, PH_PALETTE, PH_PIXELS
   } parse_phase_type;

   typedef struct packed {
      logic [pisd_pkg::BYTE_W-1:0] data;
      logic                        sof;
   } stream_byte_type;

   typedef struct packed {
      logic [pisd_pkg::COLOR_W-1:0] pixel;
      logic                         last;
      logic [1:0]                   status;
   } pixel_result_type;

   localparam logic [8:0] NO_KEY_MATCH = 9'd256;

   // header dimensions at and around the signed and MAX_DIM boundaries
   localparam logic [31:0] EXTREME_DIMS [7] = '{
      32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'd4096, 32'd4097,
      32'h7FFF_FFFF, 32'h0001_0000
   };

   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_POINTS [2] = '{40, 150};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [pisd_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                          req_start_of_file = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [pisd_pkg::COLOR_W-1:0]  rsp_pixel;
   logic                          rsp_last_pixel;
   logic [1:0]                    rsp_status;

   palette_image_stream_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel         (rsp_pixel),
      .rsp_last_pixel    (rsp_last_pixel),
      .rsp_status        (rsp_status)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Decoder state as predicted by the bench
   // ------------------------------------------------------------------------
   parse_phase_type                phase;
   logic [1:0]                     field_count;
   logic [31:0]                    shift_word;
   logic [pisd_pkg::DIM_W-1:0]     image_width;
   logic                           key_on;
   logic [pisd_pkg::COLOR_W-1:0]   key_color;
   logic [7:0]                     color_count;
   logic [pisd_pkg::COLOR_W-1:0]   palette_copy [pisd_pkg::PALETTE_DEPTH];
   logic [7:0]                     fill_index;
   logic [8:0]                     transparent_index;
   logic [pisd_pkg::PIX_W-1:0]     pixels_left;

   stream_byte_type   stream_queue [$];      // requests not yet offered
   pixel_result_type  expected_results [$];  // predicted, not yet received
   pixel_result_type  predicted;
   pixel_result_type  want;
   stream_byte_type   next_byte;

   int  mismatch_count = 0;
   int  results_seen = 0;
   int  send_gap = 0;
   int  send_calm = 0;
   int  recv_calm = 0;
   int  stall_left = 0;
   logic hold_off = 1'b0;

   function void reset_decoder();
      phase = PH_IDLE;
      field_count = '0;
      shift_word = '0;
      image_width = '0;
      key_on = 1'b0;
      key_color = '0;
      color_count = '0;
      fill_index = '0;
      transparent_index = NO_KEY_MATCH;
      pixels_left = '0;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields a result.
   function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                      output pixel_result_type res);
      logic [31:0]                   word;
      logic [pisd_pkg::DIM_W-1:0]    dim;
      logic [pisd_pkg::COLOR_W-1:0]  color;
      int                            usable;
      res = '0;
      if (sof) begin
         phase = PH_WIDTH;
         field_count = '0;
         shift_word = '0;
      end
      case (phase)
         PH_WIDTH, PH_HEIGHT: begin
            word = {shift_word[23:0], b};
            shift_word = word;
            field_count = field_count + 2'd1;
            if (field_count != 0) return 1'b0;
            shift_word = '0;
            // negative reads as zero; only positive values can be too large
            if (!word[31] && word > 32'(pisd_pkg::MAX_DIM)) begin
               phase = PH_IDLE;
               res.status = pisd_pkg::STATUS_DIM;
               return 1'b1;
            end
            dim = word[31] ? '0 : word[pisd_pkg::DIM_W-1:0];
            if (phase == PH_WIDTH) begin
               image_width = dim;
               phase = PH_HEIGHT;
            end else begin
               pixels_left = pisd_pkg::PIX_W'(image_width) * pisd_pkg::PIX_W'(dim);
               phase = PH_FLAG;
            end
            return 1'b0;
         end
         PH_FLAG: begin
            key_on = (b != 8'd0);
            field_count = '0;
            shift_word = '0;
            phase = PH_KEY;
            return 1'b0;
         end
         PH_KEY: begin
            shift_word = {16'h0, shift_word[7:0], b};
            field_count = field_count + 2'd1;
            if (field_count < 2) return 1'b0;
            key_color = shift_word[15:0];
            field_count = '0;
            shift_word = '0;
            phase = PH_COUNT;
            return 1'b0;
         end
         PH_COUNT: begin
            color_count = b;
            fill_index = '0;
            transparent_index = NO_KEY_MATCH;
            field_count = '0;
            shift_word = '0;
            if (b != 8'd0) phase = PH_PALETTE;
            else if (pixels_left != 0) phase = PH_PIXELS;
            else phase = PH_IDLE;
            return 1'b0;
         end
         PH_PALETTE: begin
            shift_word = {16'h0, shift_word[7:0], b};
            field_count = field_count + 2'd1;
            if (field_count < 2) return 1'b0;
            field_count = '0;
            if (int'(fill_index) < pisd_pkg::PALETTE_DEPTH) begin
               color = shift_word[15:0];
               palette_copy[fill_index] = color;
               if (key_on && transparent_index == NO_KEY_MATCH && color == key_color)
                  transparent_index = {1'b0, fill_index};
            end
            shift_word = '0;
            fill_index = fill_index + 8'd1;
            if (fill_index == color_count) begin
               if (pixels_left != 0) phase = PH_PIXELS;
               else phase = PH_IDLE;
            end
            return 1'b0;
         end
         PH_PIXELS: begin
            usable = (int'(color_count) < pisd_pkg::PALETTE_DEPTH) ?
                     int'(color_count) : pisd_pkg::PALETTE_DEPTH;
            if (int'(b) >= usable) begin
               phase = PH_IDLE;
               res.status = pisd_pkg::STATUS_RANGE;
               return 1'b1;
            end
            color = palette_copy[b];
            if (key_on && {1'b0, b} == transparent_index)
               color &= pisd_pkg::ALPHA_CLEAR_MASK;
            else
               color |= pisd_pkg::ALPHA_SET_BITS;
            pixels_left = pixels_left - pisd_pkg::PIX_W'(1);
            res.pixel = color;
            res.last = (pixels_left == 0);
            if (res.last) phase = PH_IDLE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stream building
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] d, input logic sof = 1'b0);
      stream_queue.push_back('{data: d, sof: sof});
   endtask

   // big-endian word; sof marks the leading byte when asked
   task automatic push_word(input logic [31:0] w, input logic sof = 1'b0);
      for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8], sof && i == 3);
   endtask

   task automatic push_color(input logic [15:0] c);
      push_byte(c[15:8]);
      push_byte(c[7:0]);
   endtask

   task automatic push_header(input logic [31:0] w, input logic [31:0] h,
                              input logic [7:0] flag, input logic [15:0] key,
                              input logic [7:0] count);
      push_word(w, 1'b1);
      push_word(h);
      push_byte(flag);
      push_color(key);
      push_byte(count);
   endtask

   // Random-content image; keep >= 0 cuts the stream after that many bytes.
   task automatic random_image(input logic [31:0] w, input logic [31:0] h,
                               input int ncolors, input int npix,
                               input int oob_pct, input int keep);
      int         first;
      logic [7:0] flag;
      logic [15:0] key;
      first = stream_queue.size();
      flag = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
      key = 16'($urandom);
      push_header(w, h, flag, key, 8'(ncolors));
      // plenty of key hits, including repeats, so the first match matters
      for (int i = 0; i < ncolors; i++)
         push_color(($urandom_range(0, 3) == 0) ? key : 16'($urandom));
      for (int i = 0; i < npix; i++) begin
         if (ncolors == 0) push_byte(8'($urandom_range(0, 255)));
         else if ($urandom_range(0, 99) < oob_pct)
            push_byte(8'($urandom_range(ncolors, 255)));
         else push_byte(8'($urandom_range(0, ncolors - 1)));
      end
      if (keep >= 0)
         while (stream_queue.size() > first + keep) void'(stream_queue.pop_back());
   endtask

   // Idle length: mostly none, some short, a few long, with calm stretches.
   function automatic int pick_idle(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 999);
      if (roll < 5) begin
         calm = $urandom_range(30, 150);
         return 0;
      end
      if (roll < 550) return 0;
      if (roll < 850) return $urandom_range(1, 3);
      if (roll < 970) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] error: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Driver: predicts each accepted request, then offers the next one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         reset_decoder();
      end else begin
         if (req_valid && !req_stall) begin
            if (decode_byte(req_data_byte, req_start_of_file, predicted))
               expected_results.push_back(predicted);
         end
         // a stalled request stays put; otherwise idle or offer the next
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (stream_queue.size() > 0) begin
               next_byte = stream_queue.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_start_of_file <= next_byte.sof;
               send_gap = pick_idle(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each accepted result, then picks the next stall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result pixel %h last %b status %0d",
                                         rsp_pixel, rsp_last_pixel, rsp_status));
            end else begin
               want = expected_results.pop_front();
               if (rsp_pixel !== want.pixel)
                  report_mismatch($sformatf("pixel %h, predicted %h", rsp_pixel, want.pixel));
               if (rsp_last_pixel !== want.last)
                  report_mismatch($sformatf("last_pixel %b, predicted %b",
                                            rsp_last_pixel, want.last));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, want.status));
            end
         end
         if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_idle(recv_calm);
         rsp_stall <= hold_off || (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Long receiver hold-offs while the sender keeps offering requests, so
   // both result buffers fill and req_stall has to rise.
   initial begin
      foreach (HOLD_POINTS[i]) begin
         wait (results_seen >= HOLD_POINTS[i]);
         @(posedge clock);
         hold_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int target;
      int w;
      int h;
      int n;
      int pick;

      // stray bytes while idle are dropped
      push_byte(8'h00);
      push_byte(8'hFF);
      // width one over the limit: error right after its last byte
      push_word(32'd4097, 1'b1);
      // largest positive height: error on the height field
      push_word(32'd1, 1'b1);
      push_word(32'h7FFF_FFFF);
      // negative width, no colors: whole header read, no result, then idle
      push_header(32'hFFFF_FFFF, 32'd3, 8'h00, 16'h0000, 8'd0);
      push_byte(8'h00);
      // zero height with a palette: palette consumed, pixel byte ignored
      push_header(32'd2, 32'd0, 8'h01, 16'h1234, 8'd1);
      push_color(16'h1234);
      push_byte(8'h00);
      // key enabled by a non-one flag; key appears twice, first one wins
      push_header(32'd2, 32'd2, 8'h80, 16'hABCD, 8'd3);
      push_color(16'h0001);
      push_color(16'hABCD);
      push_color(16'hABCD);
      push_byte(8'd1);
      push_byte(8'd2);
      push_byte(8'd0);
      push_byte(8'd1);
      // key disabled: a matching color still gets alpha set
      push_header(32'd1, 32'd1, 8'h00, 16'hF0F0, 8'd1);
      push_color(16'hF0F0);
      push_byte(8'd0);
      // no colors: every index is out of range
      push_header(32'd1, 32'd1, 8'h01, 16'h0000, 8'd0);
      push_byte(8'd0);
      // index equal to the count, then a byte that must be ignored
      push_header(32'd1, 32'd2, 8'h00, 16'h0000, 8'd2);
      push_color(16'hFFFF);
      push_color(16'h0000);
      push_byte(8'd1);
      push_byte(8'd2);
      push_byte(8'd0);
      // width at the limit, cut off mid-image by the next start
      push_header(32'd4096, 32'd1, 8'h00, 16'h0000, 8'd1);
      push_color(16'h0FFF);
      push_byte(8'd0);
      push_byte(8'd0);

      // largest palette the 8-bit count allows (255 colors), once
      random_image(32'd3, 32'd2, 255, 6, 0, -1);

      target = 1050;
      while (stream_queue.size() < target) begin
         pick = $urandom_range(0, 99);
         w = $urandom_range(1, 5);
         h = $urandom_range(1, 4);
         n = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 255) : $urandom_range(1, 8);
         if (pick < 65) begin
            random_image(w, h, n, w * h, 3, -1);
         end else if (pick < 75) begin
            // truncated image, the next start restarts the parse
            random_image(w, h, n, w * h, 0, $urandom_range(1, 12 + 2 * n + w * h - 1));
         end else if (pick < 82) begin
            if ($urandom_range(0, 1))
               random_image(EXTREME_DIMS[$urandom_range(0, 6)], h, n, 8, 0, -1);
            else
               random_image(w, EXTREME_DIMS[$urandom_range(0, 6)], n, 8, 0, -1);
         end else if (pick < 90) begin
            random_image(w, h, $urandom_range(0, 1) ? 0 : n, w * h, 40, -1);
         end else begin
            repeat ($urandom_range(1, 6))
               push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         end
      end

      wait (!reset && stream_queue.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
hdl/pisd_pkg.sv
hdl/pisd_ram.sv
hdl/pisd_parser.sv
hdl/pisd_out.sv
hdl/palette_image_stream_decoder_unit.sv
bench/testbench.sv
